// ===== design/cbta_pkg.sv =====
package cbta_pkg;

    localparam int TIME_W    = 64;
    localparam int CFG_IDX_W = 2;

    // Input kinds.
    localparam logic [1:0] KIND_BUSY  = 2'd0;
    localparam logic [1:0] KIND_IDLE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX    = 3'd1;
    localparam logic [2:0] ST_ALREADY_BUSY = 3'd2;
    localparam logic [2:0] ST_NOT_BUSY     = 3'd3;
    localparam logic [2:0] ST_BEFORE_START = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_STAMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_BUDGET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CPUS = 2'd2;

    localparam logic [3:0] ACTIVE_CPUS_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        cpu_index;
        logic [TIME_W-1:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [TIME_W-1:0] busy_sum;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] remaining;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              sub;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] res;
        logic              borrow;
    } alu_rsp_t;

endpackage

// ===== design/cbta_ram.sv =====
module cbta_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/cbta_alu.sv =====
module cbta_alu (
    input  cbta_pkg::alu_req_t req,
    output cbta_pkg::alu_rsp_t rsp
);
    import cbta_pkg::*;

    logic [TIME_W:0] full;

    // Subtraction is a + ~b + 1; a missing carry out means a borrow.
    assign full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
                + {{TIME_W{1'b0}}, req.sub};
    assign rsp.res    = full[TIME_W-1:0];
    assign rsp.borrow = req.sub & ~full[TIME_W];

endmodule

// ===== design/cbta_ctrl.sv =====
module cbta_ctrl #(
    parameter int MAX_CPUS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cbta_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cbta_pkg::out_item_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [cbta_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbta_pkg::TIME_W-1:0]    cfg_data,
    output cbta_pkg::alu_req_t   alu_req,
    input  cbta_pkg::alu_rsp_t   alu_rsp,
    output logic [((MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1)-1:0] ram_waddr,
    output logic [((MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1)-1:0] ram_raddr,
    output logic                 since_we,
    output logic [cbta_pkg::TIME_W-1:0] since_wdata,
    input  logic [cbta_pkg::TIME_W-1:0] since_rdata,
    output logic                 accum_we,
    output logic [cbta_pkg::TIME_W-1:0] accum_wdata,
    input  logic [cbta_pkg::TIME_W-1:0] accum_rdata
);
    import cbta_pkg::*;

    localparam int IDX_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CNT_W = $clog2(MAX_CPUS + 1);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_ELAPSED  = 11'b000_0000_0010,
        S_END      = 11'b000_0000_0100,
        S_REM      = 11'b000_0000_1000,
        S_STOP_SUB = 11'b000_0001_0000,
        S_STOP_ADD = 11'b000_0010_0000,
        S_SUM_RD   = 11'b000_0100_0000,
        S_SUM_ACC  = 11'b000_1000_0000,
        S_SUM_SUB  = 11'b001_0000_0000,
        S_SUM_OPEN = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [TIME_W-1:0] start_reg, budget_reg;
    logic [3:0]        active_reg;

    logic [MAX_CPUS-1:0] flag_reg, flag_next;
    logic [MAX_CPUS-1:0] aval_reg, aval_next;

    logic [1:0]        kind_reg, kind_next;
    logic [2:0]        cidx_reg, cidx_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [2:0]        status_reg, status_next;
    logic [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic [TIME_W-1:0] remain_reg, remain_next;
    logic [TIME_W-1:0] sum_reg, sum_next;
    logic [TIME_W-1:0] tmp_reg, tmp_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;

    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic [CNT_W-1:0]  n_eff;
    logic [IDX_W-1:0]  cidx_slot;
    logic              last_slot;
    logic              is_event;
    logic [TIME_W-1:0] accum_val;

    always_comb begin
        if (32'(active_reg) > MAX_CPUS) begin
            n_eff = CNT_W'(MAX_CPUS);
        end else begin
            n_eff = CNT_W'(active_reg);
        end
    end

    assign cidx_slot = IDX_W'(cidx_reg);
    assign last_slot = (32'(addr_reg) + 32'd1) == 32'(n_eff);
    assign is_event  = (kind_reg == KIND_BUSY) || (kind_reg == KIND_IDLE);
    // A slot never stopped reads as a zero total.
    assign accum_val = aval_reg[addr_reg] ? accum_rdata : '0;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign ram_raddr   = addr_next;
    assign ram_waddr   = cidx_slot;
    assign since_wdata = now_reg;
    assign accum_wdata = alu_rsp.res;

    always_comb begin
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        case (state_reg)
            S_ELAPSED: begin
                alu_req.a   = now_reg;
                alu_req.b   = start_reg;
                alu_req.sub = 1'b1;
            end
            S_END: begin
                alu_req.a = start_reg;
                alu_req.b = budget_reg;
            end
            S_REM: begin
                alu_req.a   = tmp_reg;
                alu_req.b   = now_reg;
                alu_req.sub = 1'b1;
            end
            S_STOP_SUB, S_SUM_SUB: begin
                alu_req.a   = now_reg;
                alu_req.b   = since_rdata;
                alu_req.sub = 1'b1;
            end
            S_STOP_ADD: begin
                alu_req.a = accum_val;
                alu_req.b = tmp_reg;
            end
            S_SUM_ACC: begin
                alu_req.a = sum_reg;
                alu_req.b = accum_val;
            end
            S_SUM_OPEN: begin
                alu_req.a = sum_reg;
                alu_req.b = tmp_reg;
            end
            default: begin
                alu_req.a = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        flag_next    = flag_reg;
        aval_next    = aval_reg;
        kind_next    = kind_reg;
        cidx_next    = cidx_reg;
        now_next     = now_reg;
        status_next  = status_reg;
        elapsed_next = elapsed_reg;
        remain_next  = remain_reg;
        sum_next     = sum_reg;
        tmp_next     = tmp_reg;
        addr_next    = addr_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        since_we     = 1'b0;
        accum_we     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_data.kind;
                    cidx_next  = s_data.cpu_index;
                    now_next   = s_data.now_time;
                    state_next = S_ELAPSED;
                end
            end
            S_ELAPSED: begin
                elapsed_next = alu_rsp.borrow ? '0 : alu_rsp.res;
                if (is_event) begin
                    if (32'(cidx_reg) >= 32'(n_eff)) begin
                        status_next = ST_BAD_INDEX;
                    end else if (kind_reg == KIND_BUSY && flag_reg[cidx_slot]) begin
                        status_next = ST_ALREADY_BUSY;
                    end else if (kind_reg == KIND_IDLE && !flag_reg[cidx_slot]) begin
                        status_next = ST_NOT_BUSY;
                    end else if (alu_rsp.borrow) begin
                        status_next = ST_BEFORE_START;
                    end else begin
                        status_next = ST_OK;
                    end
                end else if (alu_rsp.borrow) begin
                    status_next = ST_BEFORE_START;
                end else begin
                    status_next = ST_OK;
                end
                state_next = S_END;
            end
            S_END: begin
                tmp_next   = alu_rsp.res;
                state_next = S_REM;
            end
            S_REM: begin
                remain_next = alu_rsp.borrow ? '0 : alu_rsp.res;
                addr_next   = cidx_slot;
                state_next  = S_SUM_RD;
                if (is_event && status_reg == ST_OK) begin
                    if (kind_reg == KIND_BUSY) begin
                        since_we             = 1'b1;
                        flag_next[cidx_slot] = 1'b1;
                    end else begin
                        state_next = S_STOP_SUB;
                    end
                end
            end
            S_STOP_SUB: begin
                tmp_next   = alu_rsp.res;
                state_next = S_STOP_ADD;
            end
            S_STOP_ADD: begin
                accum_we             = 1'b1;
                aval_next[cidx_slot] = 1'b1;
                flag_next[cidx_slot] = 1'b0;
                state_next           = S_SUM_RD;
            end
            S_SUM_RD: begin
                // Any write of this item has landed, so slot reads start fresh here.
                sum_next  = '0;
                addr_next = '0;
                if (n_eff == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SUM_ACC;
                end
            end
            S_SUM_ACC: begin
                sum_next = alu_rsp.res;
                if (flag_reg[addr_reg]) begin
                    state_next = S_SUM_SUB;
                end else if (last_slot) begin
                    state_next = S_DONE;
                end else begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end
            S_SUM_SUB: begin
                tmp_next   = alu_rsp.res;
                state_next = S_SUM_OPEN;
            end
            S_SUM_OPEN: begin
                sum_next = alu_rsp.res;
                if (last_slot) begin
                    state_next = S_DONE;
                end else begin
                    addr_next  = addr_reg + IDX_W'(1);
                    state_next = S_SUM_ACC;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_data_next.status    = status_reg;
                    m_data_next.busy_sum  = sum_reg;
                    m_data_next.elapsed   = elapsed_reg;
                    m_data_next.remaining = remain_reg;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            flag_reg    <= '0;
            aval_reg    <= '0;
            m_valid_reg <= 1'b0;
            start_reg   <= '0;
            budget_reg  <= '0;
            active_reg  <= ACTIVE_CPUS_RESET;
        end else begin
            state_reg   <= state_next;
            flag_reg    <= flag_next;
            aval_reg    <= aval_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_START_STAMP: start_reg  <= cfg_data;
                    CFG_TIME_BUDGET: budget_reg <= cfg_data;
                    CFG_ACTIVE_CPUS: active_reg <= cfg_data[3:0];
                    default: begin
                        active_reg <= active_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        cidx_reg    <= cidx_next;
        now_reg     <= now_next;
        status_reg  <= status_next;
        elapsed_reg <= elapsed_next;
        remain_reg  <= remain_next;
        sum_reg     <= sum_next;
        tmp_reg     <= tmp_next;
        addr_reg    <= addr_next;
        m_data_reg  <= m_data_next;
    end

endmodule

// ===== design/cpu_busy_time_accounting_unit.sv =====
// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     in_item_t: kind, cpu_index, now_time
// m_        out        m_valid / m_ready     out_item_t: status, busy_sum, elapsed, remaining
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A request passes the elapsed, deadline and remaining steps, the stop steps for a successful
// idle event, then a sum over the N active slots. A single 64-bit adder does every sum and
// difference in turn: one step per slot, and two more for each busy slot's open interval.
// Reset is synchronous and active low; no clearing pass follows it.
// A waiting result does not block acceptance; the next result waits in its final state.
module cpu_busy_time_accounting_unit #(
    parameter int MAX_CPUS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cbta_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cbta_pkg::out_item_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [cbta_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbta_pkg::TIME_W-1:0]    cfg_data
);
    import cbta_pkg::*;

    localparam int IDX_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic              since_we, accum_we;
    logic [TIME_W-1:0] since_wdata, since_rdata, accum_wdata, accum_rdata;

    cbta_ctrl #(
        .MAX_CPUS(MAX_CPUS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .alu_req     (alu_req),
        .alu_rsp     (alu_rsp),
        .ram_waddr   (ram_waddr),
        .ram_raddr   (ram_raddr),
        .since_we    (since_we),
        .since_wdata (since_wdata),
        .since_rdata (since_rdata),
        .accum_we    (accum_we),
        .accum_wdata (accum_wdata),
        .accum_rdata (accum_rdata)
    );

    cbta_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    cbta_ram #(
        .WIDTH(TIME_W),
        .DEPTH(MAX_CPUS)
    ) u_since_ram (
        .clk   (aclk),
        .we    (since_we),
        .waddr (ram_waddr),
        .wdata (since_wdata),
        .raddr (ram_raddr),
        .rdata (since_rdata)
    );

    cbta_ram #(
        .WIDTH(TIME_W),
        .DEPTH(MAX_CPUS)
    ) u_accum_ram (
        .clk   (aclk),
        .we    (accum_we),
        .waddr (ram_waddr),
        .wdata (accum_wdata),
        .raddr (ram_raddr),
        .rdata (accum_rdata)
    );

endmodule

// ===== design/cbta_checker.sv =====
module cbta_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input cbta_pkg::in_item_t   s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input cbta_pkg::out_item_t  m_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [cbta_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [cbta_pkg::TIME_W-1:0]    cfg_data
);
    import cbta_pkg::*;

    // A stalled result keeps its contents.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Accepting a request makes the sequencer busy, so input ready drops.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a request was accepted");

    // Reset empties the output register and leaves the input side ready.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset left a result pending or input not ready");

    // A time stamp before the start stamp reports zero elapsed time.
    a_early_elapsed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_BEFORE_START |-> m_data.elapsed == '0)
        else $error("nonzero elapsed time on a clock before start");

endmodule

bind cpu_busy_time_accounting_unit cbta_checker u_checker (.*);

// ===== test/cbta_usage_checker.sv =====
module cbta_usage_checker
    import cbta_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIME_W-1:0]     cfg_data,
    output int                    pending,
    output int                    checked,
    output int                    failures
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [TIME_W-1:0] start_stamp;
    logic [TIME_W-1:0] time_budget;
    logic [3:0]        active_cpus;

    logic [TIME_W-1:0] busy_total [SLOTS];
    logic              running    [SLOTS];
    logic [TIME_W-1:0] went_busy  [SLOTS];

    out_item_t usage_report_q[$];

    initial begin
        pending  = 0;
        checked  = 0;
        failures = 0;
    end

    // Applies one request to the predicted slot state and returns the report it earns.
    function automatic out_item_t predict_usage_report(input in_item_t req);
        out_item_t         rep;
        int                slots;
        int                i;
        logic              early;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] total;
        slots = (int'(active_cpus) > SLOTS) ? SLOTS : int'(active_cpus);
        early = req.now_time < start_stamp;
        rep.status = ST_OK;
        if (req.kind == KIND_BUSY || req.kind == KIND_IDLE) begin
            if (int'(req.cpu_index) >= slots) begin
                rep.status = ST_BAD_INDEX;
            end else if (req.kind == KIND_BUSY && running[req.cpu_index]) begin
                rep.status = ST_ALREADY_BUSY;
            end else if (req.kind == KIND_IDLE && !running[req.cpu_index]) begin
                rep.status = ST_NOT_BUSY;
            end else if (early) begin
                rep.status = ST_BEFORE_START;
            end
            if (rep.status == ST_OK) begin
                if (req.kind == KIND_BUSY) begin
                    went_busy[req.cpu_index] = req.now_time;
                    running[req.cpu_index]   = 1'b1;
                end else begin
                    busy_total[req.cpu_index] += req.now_time - went_busy[req.cpu_index];
                    running[req.cpu_index]     = 1'b0;
                end
            end
        end else if (early) begin
            // Any other kind is a plain query.
            rep.status = ST_BEFORE_START;
        end

        // The sum is taken after the update, so a slot closed here counts in full.
        total = '0;
        for (i = 0; i < slots; i++) begin
            total += busy_total[i];
            if (running[i]) begin
                total += req.now_time - went_busy[i];
            end
        end
        deadline      = start_stamp + time_budget;
        rep.busy_sum  = total;
        rep.elapsed   = early ? '0 : req.now_time - start_stamp;
        rep.remaining = (deadline < req.now_time) ? '0 : deadline - req.now_time;
        return rep;
    endfunction

    function automatic void check_field(input string field, input logic [TIME_W-1:0] want,
                                        input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            start_stamp = '0;
            time_budget = '0;
            active_cpus = ACTIVE_CPUS_RESET;
            for (int j = 0; j < SLOTS; j++) begin
                busy_total[j] = '0;
                running[j]    = 1'b0;
                went_busy[j]  = '0;
            end
            usage_report_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START_STAMP: start_stamp = cfg_data;
                    CFG_TIME_BUDGET: time_budget = cfg_data;
                    CFG_ACTIVE_CPUS: active_cpus = cfg_data[3:0];
                    default: ;
                endcase
            end
            // A result leaving at this edge cannot belong to a request taken at the same edge.
            if (m_valid && m_ready) begin
                if (usage_report_q.size() == 0) begin
                    $error("result with no request outstanding: status %0d busy_sum %0h",
                           m_data.status, m_data.busy_sum);
                    failures++;
                end else begin
                    want = usage_report_q.pop_front();
                    check_field("status", TIME_W'(want.status), TIME_W'(m_data.status));
                    if (m_data.status[2:0] === m_data.status) begin
                        check_field("busy_sum", want.busy_sum, m_data.busy_sum);
                    end else begin
                        check_field("busy_sum", want.busy_sum, m_data.busy_sum);
                    end
                    check_field("elapsed", want.elapsed, m_data.elapsed);
                    check_field("remaining", want.remaining, m_data.remaining);
                    checked++;
                end
            end
            if (s_valid && s_ready) begin
                usage_report_q.push_back(predict_usage_report(s_data));
            end
        end
        pending = usage_report_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import cbta_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 8;
    localparam int SETTLE       = 40;
    localparam int RANDOM_ITEMS = 250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data  = '0;

    int pending;
    int checked;
    int failures;
    int cycles     = 0;
    int sent       = 0;
    int reg_writes = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;

    cpu_busy_time_accounting_unit #(.MAX_CPUS(SLOTS)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cbta_usage_checker #(.SLOTS(SLOTS)) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .checked   (checked),
        .failures  (failures)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding", pending);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Leaves valid high after acceptance so that a back-to-back request needs no toggle.
    task automatic send_request(input logic [1:0] kind, input logic [2:0] slot,
                                input logic [TIME_W-1:0] stamp);
        in_item_t req;
        req.kind      = kind;
        req.cpu_index = slot;
        req.now_time  = stamp;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [TIME_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        reg_writes++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    initial begin
        logic [TIME_W-1:0] run_start;
        logic [TIME_W-1:0] wall_us;
        logic [SLOTS-1:0]  shadow_busy;
        logic [TIME_W-1:0] word;
        logic [2:0]        slot;
        int                live_slots;
        int                pick;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: start at zero, no budget, all eight slots.
        send_request(KIND_QUERY, 3'd0, '0);
        send_request(KIND_IDLE, 3'd0, 64'd5);
        send_request(KIND_BUSY, 3'd0, 64'd10);
        send_request(KIND_BUSY, 3'd0, 64'd11);
        send_request(KIND_BUSY, 3'd7, TIME_MAX);
        send_request(KIND_QUERY, 3'd3, TIME_MAX);
        // Closing slot 7 at time zero wraps its interval around.
        send_request(KIND_IDLE, 3'd7, '0);
        send_request(KIND_IDLE, 3'd0, 64'd30);
        send_request(2'd3, 3'd5, 64'd40);

        wait_drained();
        write_reg(CFG_START_STAMP, 64'd1000);
        write_reg(CFG_TIME_BUDGET, 64'd500);
        write_reg(CFG_ACTIVE_CPUS, 64'd3);
        cfg_valid <= 1'b0;
        send_request(KIND_QUERY, 3'd0, 64'd999);
        send_request(KIND_BUSY, 3'd3, 64'd2000);
        // Slot is valid and idle, so only the early clock can fail it.
        send_request(KIND_BUSY, 3'd1, 64'd500);
        send_request(KIND_IDLE, 3'd1, 64'd500);
        send_request(KIND_BUSY, 3'd1, 64'd1200);
        send_request(KIND_QUERY, 3'd2, 64'd1500);
        send_request(KIND_QUERY, 3'd2, 64'd1600);
        send_request(KIND_IDLE, 3'd1, 64'd1700);

        wait_drained();
        write_reg(CFG_ACTIVE_CPUS, 64'd0);
        cfg_valid <= 1'b0;
        send_request(KIND_BUSY, 3'd0, 64'd2000);
        send_request(KIND_QUERY, 3'd6, 64'd2100);

        wait_drained();
        write_reg(CFG_ACTIVE_CPUS, {$urandom, 28'($urandom_range(0, 15)), 4'hF});
        write_reg(CFG_START_STAMP, TIME_MAX);
        write_reg(CFG_TIME_BUDGET, TIME_MAX);
        cfg_valid <= 1'b0;
        send_request(KIND_QUERY, 3'd4, TIME_MAX);
        send_request(KIND_BUSY, 3'd7, TIME_MAX);
        send_request(KIND_QUERY, 3'd2, TIME_MAX - 64'd1);

        shadow_busy = '0;
        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    idle_pct   = 0;
                    stall_pct  = 0;
                    run_start  = 64'($urandom_range(0, 1000));
                    live_slots = SLOTS;
                    write_reg(CFG_TIME_BUDGET, {$urandom, $urandom});
                end
                1: begin
                    idle_pct   = 70;
                    stall_pct  = 0;
                    run_start  = '0;
                    live_slots = $urandom_range(1, SLOTS - 1);
                    write_reg(CFG_TIME_BUDGET, TIME_MAX);
                end
                2: begin
                    idle_pct   = 0;
                    stall_pct  = 70;
                    run_start  = {$urandom, $urandom};
                    live_slots = SLOTS;
                    write_reg(CFG_TIME_BUDGET, {32'd0, $urandom});
                    write_reg(2'd3, {$urandom, $urandom});
                end
                default: begin
                    idle_pct   = 25;
                    stall_pct  = 25;
                    run_start  = 64'($urandom_range(0, 50));
                    live_slots = 1;
                    write_reg(CFG_TIME_BUDGET, 64'($urandom_range(0, 200000)));
                end
            endcase
            write_reg(CFG_START_STAMP, run_start);
            // Phase two also sets the upper data bits, which the register drops.
            word = (phase == 2) ? {$urandom, 28'($urandom_range(0, 15)), 4'hF}
                                : 64'(live_slots);
            write_reg(CFG_ACTIVE_CPUS, word);
            cfg_valid <= 1'b0;

            wall_us = run_start + 64'($urandom_range(0, 100));
            for (int k = 0; k < RANDOM_ITEMS; k++) begin
                while ($urandom_range(0, 99) < idle_pct) begin
                    s_valid <= 1'b0;
                    @(negedge aclk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    // Well-formed traffic: alternate busy and idle on an active slot.
                    slot     = 3'($urandom_range(0, live_slots - 1));
                    wall_us += 64'($urandom_range(0, 5000));
                    send_request(shadow_busy[slot] ? KIND_IDLE : KIND_BUSY, slot, wall_us);
                    shadow_busy[slot] = ~shadow_busy[slot];
                end else if (pick < 85) begin
                    send_request(KIND_QUERY, 3'($urandom_range(0, 7)), wall_us);
                end else if (pick < 92) begin
                    send_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                 {$urandom, $urandom});
                end else begin
                    send_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                 wall_us - 64'($urandom_range(0, 3000)));
                end
            end
        end

        wait_drained();
        $display("Drove %0d busy, idle and query requests with %0d register writes,",
                 sent, reg_writes);
        $display("under four pacing mixes of sender gaps and receiver stalls; %0d results checked.",
                 checked);
        if (failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
